// ===== hw/rtl/sha_eng_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha_eng_pkg
// types, access codes, round constants and helper functions for the hash engine
// ----------------------------------------------------------------------------
package sha_eng_pkg;

	localparam int QueueDepthDef = 32;

	localparam logic [2:0] OP_CTRL  = 3'd0;
	localparam logic [2:0] OP_COUNT = 3'd1;
	localparam logic [2:0] OP_HASH  = 3'd2;
	localparam logic [2:0] OP_FIFO  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [10:0] CtrlWmask = 11'h53E;
	localparam logic [31:0] EndMarker = 32'h8000_0000;
	localparam logic [31:0] ByteMarker = 32'h0000_0080;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  word_index;
		logic [31:0] bit_mask;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        write_dropped;
	} rsp_t;

	localparam logic [31:0] RoundK [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] InitHash [3][8] = '{
		'{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		  32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19},
		'{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		  32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4},
		'{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
		  32'hC3D2E1F0, 32'h00000000, 32'h00000000, 32'h00000000}
	};

	function automatic logic [31:0] swap32(logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [31:0] bsig0(logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha_eng_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha_eng_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sha_eng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_engine_with_fifo.sv =====
// every transaction's response is registered, and waits in a skid stage while the output is stalled
// a control write or a completed fifo word holds the input while the engine passes the check state
// a completed 16-word block holds the input through check, two queue reads to prime the schedule,
// 64 rounds, add and check again; in sha-1 mode only through check, one queue read, add and check
// a final request pushes a marker word, pad words to 14 mod 16 and two length words, then checks
// reset clears control state and queue pointers; queue ram, working variables and schedule window are not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_engine_with_fifo
// register mapped sha-256 / sha-224 engine with a word queue held in ram
// ----------------------------------------------------------------------------
module sha256_engine_with_fifo
	import sha_eng_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepthDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_FIN0  = 4'd2;
	localparam logic [3:0] ST_PAD   = 4'd3;
	localparam logic [3:0] ST_LENHI = 4'd4;
	localparam logic [3:0] ST_LENLO = 4'd5;
	localparam logic [3:0] ST_P0    = 4'd6;
	localparam logic [3:0] ST_P1    = 4'd7;
	localparam logic [3:0] ST_ROUND = 4'd8;
	localparam logic [3:0] ST_ADD   = 4'd9;

	logic [3:0]    state_q;
	logic [10:0]   ctrl_q;
	logic [31:0]   bc_q;
	logic [31:0]   hash_q [8];
	logic [PW-1:0] head_q;
	logic [PW-1:0] wptr_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   pw_q;
	logic [31:0]   pm_q;
	logic          running_q;
	logic          fin_q;
	logic [31:0]   ah_q [8];
	logic [31:0]   win_q [16];
	logic [5:0]    rnd_q;

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic skid_valid_q;
	rsp_t skid_q;

	logic accept;
	logic take;
	rsp_t rsp_new;

	logic          push_en;
	logic          push_ok;
	logic [31:0]   push_data;
	logic [PW-1:0] raddr;
	logic [31:0]   rdata;
	logic [PW:0]   rsum;
	logic [3:0]    roff;
	logic [PW:0]   hsum;

	logic [31:0] pw_new;
	logic [31:0] pm_new;
	logic        fifo_full16;
	logic [10:0] ctrl_new;
	logic        start;
	logic [1:0]  mode_sel;
	logic [31:0] hmask;
	logic [31:0] hval;

	logic [2:0]  fpos;
	logic [31:0] fin_word;
	logic [31:0] fin_k;
	logic [31:0] fin_adj;
	logic [31:0] len_sum;
	logic [CW:0] cnt_after;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] sched;
	logic [31:0] next_w;

	assign accept = req_valid & ~req_stall;
	assign take = rsp_valid_q & ~rsp_stall;
	assign req_stall = (state_q != ST_IDLE) | skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		rsp_new = '0;
		if (req.op == OP_READ) begin
			rsp_new.read_data = ctrl_q[3] ? swap32(hash_q[req.word_index])
				: hash_q[req.word_index];
		end
		rsp_new.write_dropped = (req.op == OP_FIFO) && fifo_full16;
	end

	assign fifo_full16 = cnt_q >= CW'(16);
	assign pw_new = pw_q | swap32(req.write_data & req.bit_mask);
	assign pm_new = pm_q | swap32(req.bit_mask);
	assign ctrl_new = (ctrl_q & ~(req.bit_mask[10:0] & CtrlWmask))
		| (req.write_data[10:0] & req.bit_mask[10:0] & CtrlWmask);
	assign start = req.write_data[0] & req.bit_mask[0] & ~ctrl_q[0];
	assign mode_sel = ctrl_new[5] ? 2'd2 : {1'b0, ctrl_new[4]};
	assign hmask = ctrl_q[3] ? swap32(req.bit_mask) : req.bit_mask;
	assign hval = ctrl_q[3] ? swap32(req.write_data & req.bit_mask)
		: (req.write_data & req.bit_mask);

	// padding word and byte adjustment for the final block
	always_comb begin
		priority if (pm_q[7]) fpos = 3'd0;
		else if (pm_q[15]) fpos = 3'd1;
		else if (pm_q[23]) fpos = 3'd2;
		else if (pm_q[31]) fpos = 3'd3;
		else fpos = 3'd4;
		if (pm_q == '0) begin
			fin_word = EndMarker;
			fin_k = '0;
		end else begin
			unique case (fpos)
				3'd0: begin
					fin_word = pw_q;
					fin_k = 32'd4;
				end
				3'd1: begin
					fin_word = pw_q | ByteMarker;
					fin_k = 32'd3;
				end
				3'd2: begin
					fin_word = pw_q | (ByteMarker << 8);
					fin_k = 32'd2;
				end
				3'd3: begin
					fin_word = pw_q | (ByteMarker << 16);
					fin_k = 32'd1;
				end
				default: begin
					fin_word = pw_q | EndMarker;
					fin_k = '0;
				end
			endcase
		end
		fin_adj = ((32'd16 - 32'(cnt_q)) << 2) - fin_k;
	end

	assign len_sum = bc_q + 32'd64;
	assign cnt_after = {1'b0, cnt_q} + (CW + 1)'(push_ok);

	always_comb begin
		push_en = 1'b0;
		push_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				push_en = accept && (req.op == OP_FIFO) && !fifo_full16 && (&pm_new);
				push_data = pw_new;
			end
			ST_FIN0: begin
				push_en = 1'b1;
				push_data = fin_word;
			end
			ST_PAD: begin
				push_en = cnt_q[3:0] != 4'd14;
				push_data = '0;
			end
			ST_LENHI: begin
				push_en = 1'b1;
				push_data = {29'd0, len_sum[31:29]};
			end
			ST_LENLO: begin
				push_en = 1'b1;
				push_data = {len_sum[28:0], 3'd0};
			end
			default: begin
				push_en = 1'b0;
				push_data = '0;
			end
		endcase
	end

	assign push_ok = push_en && (cnt_q < CW'(QUEUE_DEPTH));

	always_comb begin
		unique case (state_q)
			ST_P0: roff = 4'd0;
			ST_P1: roff = 4'd1;
			default: roff = rnd_q[3:0] + 4'd2;
		endcase
		rsum = {1'b0, head_q} + (PW + 1)'(roff);
		if (rsum >= (PW + 1)'(QUEUE_DEPTH)) begin
			rsum = rsum - (PW + 1)'(QUEUE_DEPTH);
		end
		raddr = rsum[PW-1:0];
		hsum = {1'b0, head_q} + (PW + 1)'(16);
		if (hsum >= (PW + 1)'(QUEUE_DEPTH)) begin
			hsum = hsum - (PW + 1)'(QUEUE_DEPTH);
		end
	end

	sha_eng_ram #(
		.WIDTH (32),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wptr_q),
		.wdata (push_data),
		.raddr (raddr),
		.rdata (rdata)
	);

	// one compression round
	assign t1 = bsig1(ah_q[4]) + ((ah_q[4] & ah_q[5]) ^ (~ah_q[4] & ah_q[6])) + ah_q[7]
		+ win_q[15] + RoundK[rnd_q];
	assign t2 = bsig0(ah_q[0])
		+ ((ah_q[0] & ah_q[1]) ^ (ah_q[0] & ah_q[2]) ^ (ah_q[1] & ah_q[2]));
	assign sched = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign next_w = (rnd_q < 6'd15) ? rdata : sched;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctrl_q <= '0;
			bc_q <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= '0;
			end
			head_q <= '0;
			wptr_q <= '0;
			cnt_q <= '0;
			pw_q <= '0;
			pm_q <= '0;
			running_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			if (push_ok) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				cnt_q <= cnt_after[CW-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_CTRL: begin
								ctrl_q <= ctrl_new;
								if (start) begin
									running_q <= 1'b1;
									bc_q <= '0;
									for (int i = 0; i < 8; i++) begin
										hash_q[i] <= InitHash[mode_sel][i];
									end
								end
								if ((start || running_q) && ctrl_new[1]) begin
									fin_q <= 1'b1;
									state_q <= ST_FIN0;
								end else begin
									state_q <= ST_CHECK;
								end
							end
							OP_COUNT: begin
								bc_q <= (bc_q & ~req.bit_mask)
									| (req.write_data & req.bit_mask);
							end
							OP_HASH: begin
								hash_q[req.word_index] <= (hash_q[req.word_index] & ~hmask)
									| hval;
							end
							OP_FIFO: begin
								if (!fifo_full16) begin
									if (&pm_new) begin
										pw_q <= '0;
										pm_q <= '0;
										state_q <= ST_CHECK;
									end else begin
										pw_q <= pw_new;
										pm_q <= pm_new;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FIN0: begin
					bc_q <= bc_q - fin_adj;
					pw_q <= '0;
					pm_q <= '0;
					state_q <= ST_PAD;
				end
				ST_PAD: begin
					if (!push_ok) begin
						state_q <= ST_LENHI;
					end
				end
				ST_LENHI: begin
					state_q <= ST_LENLO;
				end
				ST_LENLO: begin
					if (cnt_after > (CW + 1)'(16)) begin
						bc_q <= bc_q - 32'd64;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (running_q && fifo_full16) begin
						state_q <= ST_P0;
					end else begin
						if (fin_q) begin
							fin_q <= 1'b0;
							running_q <= 1'b0;
							ctrl_q[1] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_P0: begin
					state_q <= ctrl_q[5] ? ST_ADD : ST_P1;
				end
				ST_P1: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!ctrl_q[5]) begin
						for (int i = 0; i < 8; i++) begin
							hash_q[i] <= hash_q[i] + ah_q[i];
						end
					end
					head_q <= hsum[PW-1:0];
					cnt_q <= cnt_q - CW'(16);
					bc_q <= bc_q + 32'd64;
					state_q <= ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working variables and message schedule window
	always_ff @(posedge clk) begin
		if (state_q == ST_P0) begin
			for (int i = 0; i < 8; i++) begin
				ah_q[i] <= hash_q[i];
			end
		end
		if (state_q == ST_ROUND) begin
			ah_q[0] <= t1 + t2;
			ah_q[1] <= ah_q[0];
			ah_q[2] <= ah_q[1];
			ah_q[3] <= ah_q[2];
			ah_q[4] <= ah_q[3] + t1;
			ah_q[5] <= ah_q[4];
			ah_q[6] <= ah_q[5];
			ah_q[7] <= ah_q[6];
		end
		if (state_q == ST_P1 || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= (state_q == ST_P1) ? rdata : next_w;
		end
	end

	// response register with a skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= accept;
				end
			end else if (rsp_valid_q) begin
				if (accept) begin
					skid_valid_q <= 1'b1;
				end
			end else begin
				rsp_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			rsp_q <= skid_q;
		end else if (accept && (take || !rsp_valid_q)) begin
			rsp_q <= rsp_new;
		end
		if (accept && rsp_valid_q && !take) begin
			skid_q <= rsp_new;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && running_q) |-> cnt_q < CW'(16))
		else $error("running engine idle with a full block queued");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid stage holds a response ahead of the output register");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !fin_q)
		else $error("final request left pending while idle");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P0) |-> (running_q && cnt_q >= CW'(16)))
		else $error("block started without sixteen queued words");
`endif

endmodule
`default_nettype wire
